// File: hdl/i2c_master_bit_sequencer_assert.svh
// ---------------------------------------------------------------------------
// i2c master bit sequencer assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define I2CBS_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("i2cbs assertion failed");
// next-cycle implication
`define I2CBS_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("i2cbs assertion failed");
`else
`define I2CBS_ASSERT_IMP(name, ck, rn, ante, cons)
`define I2CBS_ASSERT_NXT(name, ck, rn, ante, cons)
`endif
`endif

// File: hdl/i2cbs_pkg.sv
// ---------------------------------------------------------------------------
// i2cbs_pkg
// shared types and constants of the i2c master bit sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

  // request operation codes
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_STOP     = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_SEND_ACK = 3'd4;
  localparam logic [2:0] OP_READ_ACK = 3'd5;
  localparam logic [2:0] OP_SAMPLE   = 3'd6;

  localparam logic [15:0] HOLD_RESET = 16'd720;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  typedef enum logic [3:0] {
    RK_REJECT,
    RK_START,
    RK_STOP,
    RK_WRITE,
    RK_SEND_ACK,
    RK_READ,
    RK_READ_ACK,
    RK_SMP_ACK,
    RK_SMP_DONE,
    RK_SMP_MORE
  } run_kind_t;

  // one classified request: kind, line levels at its start and its operand
  typedef struct packed {
    run_kind_t   kind;
    logic        scl;
    logic        sda;
    logic [7:0]  data;
    logic        bit_v;
  } run_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        sample_request;
    logic        last_of_run;
    logic        op_complete;
    logic [7:0]  read_data;
    logic        ack_received;
    logic        rejected;
  } step_t;

endpackage

`default_nettype wire

// File: hdl/i2cbs_front.sv
// ---------------------------------------------------------------------------
// i2cbs_front
// accepts requests, checks them against the sample wait and keeps bus state
// ---------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_bit_sequencer_assert.svh"

module i2cbs_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        in_operation,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_ack_bit,
  input  wire logic              in_sda_sampled,
  input  wire logic              q_full,
  output logic                   q_push,
  output i2cbs_pkg::run_t        q_run
);
  import i2cbs_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_BYTE, PH_ACK} phase_t;

  phase_t      phase_r,  phase_nxt;
  logic        scl_r,    scl_nxt;
  logic        sda_r,    sda_nxt;
  logic [7:0]  shift_r,  shift_nxt;
  logic [3:0]  bidx_r,   bidx_nxt;
  logic        acc;
  logic [3:0]  bidx_inc;
  logic [7:0]  shift_in;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign q_push   = acc;
  assign bidx_inc = bidx_r + 4'd1;
  assign shift_in = {shift_r[6:0], in_sda_sampled};

  always_comb begin
    phase_nxt   = phase_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    shift_nxt   = shift_r;
    bidx_nxt    = bidx_r;
    q_run.kind  = RK_REJECT;
    q_run.scl   = scl_r;
    q_run.sda   = sda_r;
    q_run.data  = in_data_byte;
    q_run.bit_v = in_ack_bit;
    // a command while a sample is awaited is refused
    if (phase_r != PH_IDLE && in_operation != OP_SAMPLE) begin
      q_run.kind = RK_REJECT;
    end else begin
      case (in_operation)
        OP_START: begin
          q_run.kind = RK_START;
          scl_nxt    = 1'b0;
          sda_nxt    = 1'b0;
        end
        OP_STOP: begin
          q_run.kind = RK_STOP;
          scl_nxt    = 1'b1;
          sda_nxt    = 1'b1;
        end
        OP_WRITE: begin
          q_run.kind = RK_WRITE;
          scl_nxt    = 1'b0;
          sda_nxt    = in_data_byte[0];
        end
        OP_SEND_ACK: begin
          q_run.kind = RK_SEND_ACK;
          scl_nxt    = 1'b0;
          sda_nxt    = in_ack_bit;
        end
        OP_READ: begin
          q_run.kind = RK_READ;
          scl_nxt    = 1'b1;
          sda_nxt    = 1'b1;
          shift_nxt  = 8'd0;
          bidx_nxt   = 4'd0;
          phase_nxt  = PH_BYTE;
        end
        OP_READ_ACK: begin
          q_run.kind = RK_READ_ACK;
          scl_nxt    = 1'b1;
          sda_nxt    = 1'b1;
          phase_nxt  = PH_ACK;
        end
        OP_SAMPLE: begin
          q_run.bit_v = in_sda_sampled;
          if (phase_r == PH_ACK) begin
            q_run.kind = RK_SMP_ACK;
            scl_nxt    = 1'b0;
            phase_nxt  = PH_IDLE;
          end else if (phase_r == PH_BYTE) begin
            shift_nxt = shift_in;
            if (bidx_inc >= 4'd8) begin
              q_run.kind = RK_SMP_DONE;
              q_run.data = shift_in;
              scl_nxt    = 1'b0;
              bidx_nxt   = 4'd0;
              phase_nxt  = PH_IDLE;
            end else begin
              // clock low then high again for the next bit
              q_run.kind = RK_SMP_MORE;
              scl_nxt    = 1'b1;
              bidx_nxt   = bidx_inc;
            end
          end else begin
            q_run.kind = RK_REJECT;
          end
        end
        default: begin
          q_run.kind = RK_REJECT;
        end
      endcase
    end
    if (q_run.kind == RK_REJECT) begin
      phase_nxt = phase_r;
      scl_nxt   = scl_r;
      sda_nxt   = sda_r;
      shift_nxt = shift_r;
      bidx_nxt  = bidx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      shift_r <= 8'd0;
      bidx_r  <= 4'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      shift_r <= shift_nxt;
      bidx_r  <= bidx_nxt;
    end
  end

  `I2CBS_ASSERT_IMP(a_byte_count_range, clk, rst_n, phase_r == PH_BYTE, bidx_r < 4'd8)
  `I2CBS_ASSERT_IMP(a_count_clear_off_byte, clk, rst_n, phase_r != PH_BYTE, bidx_r == 4'd0)
  `I2CBS_ASSERT_NXT(a_read_enters_wait, clk, rst_n, acc && q_run.kind == RK_READ, phase_r == PH_BYTE)

endmodule

`default_nettype wire

// File: hdl/i2cbs_queue.sv
// ---------------------------------------------------------------------------
// i2cbs_queue
// short request queue decoupling the front from the line sequencer
// ---------------------------------------------------------------------------
`default_nettype none

module i2cbs_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  i2cbs_pkg::run_t        push_run,
  output logic                   full,
  input  wire logic              pop,
  output i2cbs_pkg::run_t        pop_run,
  output logic                   empty
);
  import i2cbs_pkg::*;

  run_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r,    cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == QCW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_run = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

`default_nettype wire

// File: hdl/i2cbs_back.sv
// ---------------------------------------------------------------------------
// i2cbs_back
// expands queued requests into line steps, each held for the hold time
// ---------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_bit_sequencer_assert.svh"

module i2cbs_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [15:0]       hold_cycles,
  input  i2cbs_pkg::run_t        q_run,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output i2cbs_pkg::step_t       out_step
);
  import i2cbs_pkg::*;

  run_t        cur_r;
  logic        active_r, active_nxt;
  logic [1:0]  phs_r,    phs_nxt;
  logic [2:0]  bit_r,    bit_nxt;
  logic [15:0] wait_r,   wait_nxt;
  logic        valid_r,  valid_nxt;
  step_t       outq_r;
  step_t       stp;
  logic        emit;
  logic        taken;
  logic        wbit;

  assign taken     = valid_r && !out_stall;
  assign emit      = active_r && !valid_r && (wait_r == '0);
  assign q_pop     = !active_r && !q_empty;
  assign out_valid = valid_r;
  assign out_step  = outq_r;
  assign wbit      = cur_r.data[3'd7 - bit_r];

  // step generator
  always_comb begin
    stp = '0;
    stp.scl = cur_r.scl;
    stp.sda = cur_r.sda;
    case (cur_r.kind)
      RK_REJECT: begin
        stp.rejected    = 1'b1;
        stp.last_of_run = 1'b1;
      end
      RK_START: begin
        case (phs_r)
          2'd0: begin stp.sda = 1'b1; end
          2'd1: begin stp.scl = 1'b1; stp.sda = 1'b1; end
          2'd2: begin stp.scl = 1'b1; stp.sda = 1'b0; end
          default: begin
            stp.scl = 1'b0;
            stp.sda = 1'b0;
            stp.op_complete = 1'b1;
            stp.last_of_run = 1'b1;
          end
        endcase
      end
      RK_STOP: begin
        case (phs_r)
          2'd0: begin stp.sda = 1'b0; end
          2'd1: begin stp.scl = 1'b1; stp.sda = 1'b0; end
          default: begin
            stp.scl = 1'b1;
            stp.sda = 1'b1;
            stp.op_complete = 1'b1;
            stp.last_of_run = 1'b1;
          end
        endcase
      end
      RK_WRITE: begin
        stp.sda = wbit;
        case (phs_r)
          2'd0: begin stp.scl = (bit_r == 3'd0) ? cur_r.scl : 1'b0; end
          2'd1: begin stp.scl = 1'b1; end
          default: begin
            stp.scl = 1'b0;
            stp.op_complete = (bit_r == 3'd7);
            stp.last_of_run = (bit_r == 3'd7);
          end
        endcase
      end
      RK_SEND_ACK: begin
        stp.sda = cur_r.bit_v;
        case (phs_r)
          2'd0: begin stp.scl = cur_r.scl; end
          2'd1: begin stp.scl = 1'b1; end
          default: begin
            stp.scl = 1'b0;
            stp.op_complete = 1'b1;
            stp.last_of_run = 1'b1;
          end
        endcase
      end
      RK_READ, RK_READ_ACK: begin
        stp.sda = 1'b1;
        if (phs_r != 2'd0) begin
          stp.scl            = 1'b1;
          stp.sample_request = 1'b1;
          stp.last_of_run    = 1'b1;
        end
      end
      RK_SMP_ACK: begin
        stp.scl          = 1'b0;
        stp.ack_received = cur_r.bit_v;
        stp.op_complete  = 1'b1;
        stp.last_of_run  = 1'b1;
      end
      RK_SMP_DONE: begin
        stp.scl         = 1'b0;
        stp.read_data   = cur_r.data;
        stp.op_complete = 1'b1;
        stp.last_of_run = 1'b1;
      end
      RK_SMP_MORE: begin
        if (phs_r == 2'd0) begin
          stp.scl = 1'b0;
        end else begin
          stp.scl            = 1'b1;
          stp.sample_request = 1'b1;
          stp.last_of_run    = 1'b1;
        end
      end
      default: begin
        stp.rejected    = 1'b1;
        stp.last_of_run = 1'b1;
      end
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    phs_nxt    = phs_r;
    bit_nxt    = bit_r;
    wait_nxt   = wait_r;
    valid_nxt  = valid_r;
    if (taken) begin
      valid_nxt = 1'b0;
      // hold the line state before the next step
      wait_nxt  = (hold_cycles == '0) ? '0 : hold_cycles - 16'd1;
    end else if (wait_r != '0) begin
      wait_nxt = wait_r - 16'd1;
    end
    if (q_pop) begin
      active_nxt = 1'b1;
      phs_nxt    = 2'd0;
      bit_nxt    = 3'd0;
    end else if (emit) begin
      valid_nxt = 1'b1;
      if (stp.last_of_run) begin
        active_nxt = 1'b0;
      end else if (cur_r.kind == RK_WRITE && phs_r == 2'd2) begin
        phs_nxt = 2'd0;
        bit_nxt = bit_r + 3'd1;
      end else begin
        phs_nxt = phs_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phs_r    <= 2'd0;
      bit_r    <= 3'd0;
      wait_r   <= '0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      phs_r    <= phs_nxt;
      bit_r    <= bit_nxt;
      wait_r   <= wait_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_run;
    end
    if (emit) begin
      outq_r <= stp;
    end
  end

  `I2CBS_ASSERT_IMP(a_no_step_in_hold, clk, rst_n, valid_r, wait_r == '0)
  `I2CBS_ASSERT_NXT(a_last_ends_run, clk, rst_n, emit && stp.last_of_run, !active_r)
  `I2CBS_ASSERT_IMP(a_reject_is_last, clk, rst_n, valid_r && outq_r.rejected, outq_r.last_of_run)

endmodule

`default_nettype wire

// File: hdl/i2c_master_bit_sequencer.sv
// ---------------------------------------------------------------------------
// i2c_master_bit_sequencer
// open-drain i2c master line sequencer: requests in, paced line steps out
//
//   channel  direction  handshake            payload
//   in_      to block   in_valid/in_stall    operation, data_byte, ack_bit, sda_sampled
//   out_     from block out_valid/out_stall  scl/sda levels, sample_request, status
//   cfg_     to block   cfg_wr_en            hold_cycles (16 bit)
//
// each line step is shown for at least the hold time, set by the hold
// counter in the back end from hold_cycles; a write byte takes 24 steps.
// requests are taken one a cycle while the four-entry queue has room.
// out_stall only stretches the current step.
// synchronous reset; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_ack_bit,
  input  wire logic        in_sda_sampled,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_scl_out,
  output logic             out_sda_out,
  output logic             out_sample_request,
  output logic             out_last_of_run,
  output logic             out_op_complete,
  output logic [7:0]       out_read_data,
  output logic             out_ack_received,
  output logic             out_rejected
);
  import i2cbs_pkg::*;

  logic [15:0] hold_r;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  run_t        push_run;
  run_t        pop_run;
  step_t       step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
    end else if (cfg_wr_en) begin
      hold_r <= cfg_wr_data;
    end
  end

  i2cbs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .in_ack_bit     (in_ack_bit),
    .in_sda_sampled (in_sda_sampled),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_run          (push_run)
  );

  i2cbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_run (push_run),
    .full     (q_full),
    .pop      (q_pop),
    .pop_run  (pop_run),
    .empty    (q_empty)
  );

  i2cbs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .hold_cycles (hold_r),
    .q_run       (pop_run),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_step    (step)
  );

  assign out_scl_out        = step.scl;
  assign out_sda_out        = step.sda;
  assign out_sample_request = step.sample_request;
  assign out_last_of_run    = step.last_of_run;
  assign out_op_complete    = step.op_complete;
  assign out_read_data      = step.read_data;
  assign out_ack_received   = step.ack_received;
  assign out_rejected       = step.rejected;

endmodule

`default_nettype wire

// File: dv/tb.sv
// ---------------------------------------------------------------------------
// tb: i2c master bit sequencer testbench
// drives bus requests and sda samples, works out the expected line steps of
// every accepted request and checks each returned step field by field, over
// hold settings 720, 1, 65535 and 2, with random idling on both
// sides, a long receiver hold-off and a sender pause
// ---------------------------------------------------------------------------
module tb;
  import i2cbs_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int IDLE_PCT = 13;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 300000;

  typedef enum logic [1:0] {RX_IDLE, RX_BYTE, RX_ACK} rx_wait_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       ackb;
    logic       smp;
  } line_request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_ack_bit = 1'b0;
  logic        in_sda_sampled = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_sample_request;
  logic        out_last_of_run;
  logic        out_op_complete;
  logic [7:0]  out_read_data;
  logic        out_ack_received;
  logic        out_rejected;

  i2c_master_bit_sequencer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_data_byte       (in_data_byte),
    .in_ack_bit         (in_ack_bit),
    .in_sda_sampled     (in_sda_sampled),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_scl_out        (out_scl_out),
    .out_sda_out        (out_sda_out),
    .out_sample_request (out_sample_request),
    .out_last_of_run    (out_last_of_run),
    .out_op_complete    (out_op_complete),
    .out_read_data      (out_read_data),
    .out_ack_received   (out_ack_received),
    .out_rejected       (out_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_request_t pending_requests[$];
  step_t         expected_steps[$];

  // predicted sequencer state
  logic     line_scl, line_sda;
  logic [7:0] rx_shift;
  logic [3:0] rx_count;
  rx_wait_t rx_wait;
  int       hold_setting = 720;

  int mismatch_count = 0;
  int steps_checked = 0;
  int queued_items = 0;
  int bytes_written = 0;
  int bytes_read = 0;
  int acks_sampled = 0;
  int refusals = 0;

  bit sender_paused = 0;
  bit quiet_stretch = 0;
  bit pressure_phase = 0;
  int hold_off_cnt = 0;
  bit hold_off_used = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at step %0d: %s", steps_checked, what);
    mismatch_count++;
  endtask

  function automatic void emit_step(input logic req, input logic done, input logic [7:0] rd,
                                    input logic ack, input logic rej);
    step_t s;
    s.scl = line_scl;
    s.sda = line_sda;
    s.sample_request = req;
    s.last_of_run = 1'b0;
    s.op_complete = done;
    s.read_data = rd;
    s.ack_received = ack;
    s.rejected = rej;
    expected_steps.push_back(s);
  endfunction

  function automatic void set_sda(input logic v, input logic req, input logic done);
    line_sda = v;
    emit_step(req, done, 8'h00, 1'b0, 1'b0);
  endfunction

  function automatic void set_scl(input logic v, input logic req, input logic done);
    line_scl = v;
    emit_step(req, done, 8'h00, 1'b0, 1'b0);
  endfunction

  function automatic void predict_line_steps(input line_request_t r);
    step_t tail;
    bit refuse;
    refuse = (r.op == OP_UNUSED) || (r.op == OP_SAMPLE && rx_wait == RX_IDLE) ||
             (r.op != OP_SAMPLE && rx_wait != RX_IDLE);
    if (refuse) begin
      emit_step(1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
      refusals++;
    end else begin
      case (r.op)
        OP_START: begin
          set_sda(1'b1, 1'b0, 1'b0);
          set_scl(1'b1, 1'b0, 1'b0);
          set_sda(1'b0, 1'b0, 1'b0);
          set_scl(1'b0, 1'b0, 1'b1);
        end
        OP_STOP: begin
          set_sda(1'b0, 1'b0, 1'b0);
          set_scl(1'b1, 1'b0, 1'b0);
          set_sda(1'b1, 1'b0, 1'b1);
        end
        OP_WRITE: begin
          for (int i = 7; i >= 0; i--) begin
            set_sda(r.data[i], 1'b0, 1'b0);
            set_scl(1'b1, 1'b0, 1'b0);
            set_scl(1'b0, 1'b0, i == 0);
          end
          bytes_written++;
        end
        OP_SEND_ACK: begin
          set_sda(r.ackb, 1'b0, 1'b0);
          set_scl(1'b1, 1'b0, 1'b0);
          set_scl(1'b0, 1'b0, 1'b1);
        end
        OP_READ: begin
          rx_shift = 8'h00;
          rx_count = 4'd0;
          set_sda(1'b1, 1'b0, 1'b0);
          set_scl(1'b1, 1'b1, 1'b0);
          rx_wait = RX_BYTE;
        end
        OP_READ_ACK: begin
          set_sda(1'b1, 1'b0, 1'b0);
          set_scl(1'b1, 1'b1, 1'b0);
          rx_wait = RX_ACK;
        end
        default: begin
          line_scl = 1'b0;
          if (rx_wait == RX_ACK) begin
            emit_step(1'b0, 1'b1, 8'h00, r.smp, 1'b0);
            rx_wait = RX_IDLE;
            acks_sampled++;
          end else begin
            rx_shift = {rx_shift[6:0], r.smp};
            rx_count = rx_count + 4'd1;
            if (rx_count >= 4'd8) begin
              emit_step(1'b0, 1'b1, rx_shift, 1'b0, 1'b0);
              rx_count = 4'd0;
              rx_wait = RX_IDLE;
              bytes_read++;
            end else begin
              emit_step(1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
              set_scl(1'b1, 1'b1, 1'b0);
            end
          end
        end
      endcase
    end
    tail = expected_steps.pop_back();
    tail.last_of_run = 1'b1;
    expected_steps.push_back(tail);
  endfunction

  // driver: a request stays put while stalled, otherwise the next one may follow
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_requests.size() != 0 && !sender_paused &&
          (quiet_stretch || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_operation <= pending_requests[0].op;
        in_data_byte <= pending_requests[0].data;
        in_ack_bit <= pending_requests[0].ackb;
        in_sda_sampled <= pending_requests[0].smp;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off when pressure is asked for
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (pressure_phase && !hold_off_used) begin
      out_stall <= 1'b1;
      hold_off_cnt <= HOLD_OFF_CYCLES;
      hold_off_used <= 1'b1;
    end else if (hold_off_cnt != 0) begin
      out_stall <= 1'b1;
      hold_off_cnt <= hold_off_cnt - 1;
    end else begin
      out_stall <= !quiet_stretch && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor: predict on accepted requests, then check accepted steps
  always @(posedge clk) begin : monitor
    step_t got, want;
    if (!rst_n) begin
      line_scl <= 1'b1;
      line_sda <= 1'b1;
      rx_shift <= 8'h00;
      rx_count <= 4'd0;
      rx_wait <= RX_IDLE;
    end else begin
      if (in_valid && !in_stall)
        predict_line_steps('{in_operation, in_data_byte, in_ack_bit, in_sda_sampled});
      if (out_valid && !out_stall) begin
        got = '{out_scl_out, out_sda_out, out_sample_request, out_last_of_run,
                out_op_complete, out_read_data, out_ack_received, out_rejected};
        if (expected_steps.size() == 0) begin
          report_mismatch($sformatf("unexpected step %p", got));
        end else begin
          want = expected_steps.pop_front();
          if (got.scl !== want.scl)
            report_mismatch($sformatf("scl_out %b, want %b", got.scl, want.scl));
          if (got.sda !== want.sda)
            report_mismatch($sformatf("sda_out %b, want %b", got.sda, want.sda));
          if (got.sample_request !== want.sample_request)
            report_mismatch($sformatf("sample_request %b, want %b",
                                      got.sample_request, want.sample_request));
          if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b",
                                      got.last_of_run, want.last_of_run));
          if (got.op_complete !== want.op_complete)
            report_mismatch($sformatf("op_complete %b, want %b",
                                      got.op_complete, want.op_complete));
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
          if (got.ack_received !== want.ack_received)
            report_mismatch($sformatf("ack_received %b, want %b",
                                      got.ack_received, want.ack_received));
          if (got.rejected !== want.rejected)
            report_mismatch($sformatf("rejected %b, want %b", got.rejected, want.rejected));
        end
        steps_checked++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_request(input logic [2:0] op, input logic [7:0] data,
                             input logic ackb, input logic smp);
    pending_requests.push_back('{op, data, ackb, smp});
    queued_items++;
  endtask

  // operands that the operation ignores are random
  task automatic add_random_request(input logic [2:0] op);
    add_request(op, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic add_samples(input int count);
    repeat (count) add_random_request(OP_SAMPLE);
  endtask

  // well-formed transfers mostly, with noise and broken reads in between
  task automatic add_random_traffic(input int count);
    int goal;
    int cut;
    goal = queued_items + count;
    while (queued_items < goal) begin
      if ($urandom_range(99) < 75) begin
        add_random_request(OP_START);
        add_random_request(OP_WRITE);
        add_random_request(OP_READ_ACK);
        add_samples(1);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1)) begin
            add_random_request(OP_WRITE);
            add_random_request(OP_READ_ACK);
            add_samples(1);
          end else begin
            add_random_request(OP_READ);
            add_samples(8);
            add_random_request(OP_SEND_ACK);
          end
        end
        add_random_request(OP_STOP);
      end else if ($urandom_range(1)) begin
        add_random_request(3'($urandom_range(7)));
      end else begin
        // read cut short by a stray request, then finished
        cut = $urandom_range(7);
        add_random_request(OP_READ);
        add_samples(cut);
        add_random_request($urandom_range(1) ? OP_UNUSED : 3'($urandom_range(5)));
        add_samples(8 - cut);
      end
    end
  endtask

  task automatic settle();
    while (pending_requests.size() != 0 || in_valid || expected_steps.size() != 0)
      @(negedge clk);
    repeat (hold_setting + 8) @(negedge clk);
  endtask

  task automatic write_hold(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hold_setting = int'(value);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at the reset hold setting
    add_request(OP_START, 8'h00, 1'b0, 1'b0);
    add_request(OP_WRITE, 8'h00, 1'b1, 1'b1);
    add_request(OP_WRITE, 8'hFF, 1'b0, 1'b0);
    add_request(OP_READ_ACK, 8'h5A, 1'b1, 1'b1);
    add_request(OP_SAMPLE, 8'hA5, 1'b0, 1'b0);
    add_request(OP_SEND_ACK, 8'h00, 1'b0, 1'b1);
    add_request(OP_READ, 8'hFF, 1'b1, 1'b0);
    add_request(OP_START, 8'h12, 1'b0, 1'b1);
    add_request(OP_UNUSED, 8'h34, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++)
      add_request(OP_SAMPLE, 8'($urandom), 1'($urandom), 1'(8'hB3 >> (7 - i)));
    add_request(OP_SEND_ACK, 8'hFF, 1'b1, 1'b0);
    add_request(OP_READ_ACK, 8'h00, 1'b0, 1'b0);
    add_request(OP_SAMPLE, 8'h00, 1'b0, 1'b1);
    add_request(OP_WRITE, 8'hA5, 1'b0, 1'b0);
    add_request(OP_STOP, 8'hFF, 1'b1, 1'b1);
    add_request(OP_SAMPLE, 8'h00, 1'b0, 1'b1);
    add_request(OP_UNUSED, 8'hFF, 1'b1, 1'b1);
    settle();

    // fastest stepping, with the receiver holding off long enough to back up the queue
    write_hold(16'd1);
    add_random_traffic(30);
    pressure_phase = 1'b1;
    settle();

    // slowest stepping, a single one-step request
    write_hold(16'hFFFF);
    add_random_request(OP_SAMPLE);
    settle();

    write_hold(16'd2);
    add_random_traffic(30);
    while (pending_requests.size() > 28) @(negedge clk);
    sender_paused = 1'b1;
    while (in_valid || expected_steps.size() != 0) @(negedge clk);
    sender_paused = 1'b0;
    quiet_stretch = 1'b1;
    while (pending_requests.size() > 12) @(negedge clk);
    quiet_stretch = 1'b0;
    settle();

    $display("%0d requests, %0d line steps checked; hold 720, 1, 65535 and 2",
             queued_items, steps_checked);
    $display("%0d bytes written, %0d read, %0d acks sampled, %0d requests refused",
             bytes_written, bytes_read, acks_sampled, refusals);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/i2cbs_pkg.sv
hdl/i2cbs_front.sv
hdl/i2cbs_queue.sv
hdl/i2cbs_back.sv
hdl/i2c_master_bit_sequencer.sv
dv/tb.sv
